/* hw/rtl/ldwf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Largest descent window finder package
// Widths, types and the drop saturation shared by the descent finder.
// ----------------------------------------------------------------------------
package ldwf_pkg;

    localparam int TIME_BITS = 48;
    localparam int ALT_W     = 26;
    localparam int DROP_W    = 25;
    localparam int TMO_W     = 20;

    typedef logic signed [ALT_W-1:0] t_alt;
    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [TIME_BITS:0]      t_time_x;
    typedef logic [DROP_W-1:0]       t_drop;
    typedef logic [TMO_W-1:0]        t_tmo;

    localparam t_tmo  TMO_RESET = t_tmo'(10000);
    localparam t_drop DROP_MAX  = '1;

    // Snapshot of the closed track, handed from the state update to the
    // window calculation.
    typedef struct packed {
        t_drop drop;
        t_time high_time;
        t_time low_time;
        t_time track_start;
        t_time last_time;
    } t_fin;

    // Positive difference hi - lo, clipped to the drop range.
    function automatic t_drop sat_drop(input t_alt hi, input t_alt lo);
        logic signed [ALT_W:0] d;
        d = {hi[ALT_W-1], hi} - {lo[ALT_W-1], lo};
        if (d[ALT_W] || (d == '0)) begin
            return '0;
        end else if (d[ALT_W-1]) begin
            return DROP_MAX;
        end else begin
            return d[DROP_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/largest_descent_window_finder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Largest descent window finder unit
// Follows altitude descents over a track and reports the padded time window
// of the largest drop when the track's last sample arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the input channel (i_in_valid / o_in_ready), one word per
//   sample: altitude, timestamp and the first and last sample flags. Only a
//   word flagged as the last sample produces a result word on the output
//   channel (o_out_valid / i_out_ready).
//   The block takes one word per cycle while o_in_ready is high. A result word
//   passes from the input register through the state update, which closes
//   the track into the snapshot register, and then through the window
//   calculation into the output register.
//   The pause timeout register is written through i_cfg_we / i_cfg_wdata at
//   any edge with the enable high; write it only while the block is idle.
//   Reset clears all descent tracking, empties the pipeline and sets the
//   timeout to 10000 ms.
//   When the receiver stalls, ordinary samples keep flowing through the state
//   update. Closed tracks queue first in the output register and then in the
//   snapshot register; a third last sample then waits in the input register,
//   and only then does o_in_ready drop.
// ----------------------------------------------------------------------------
module largest_descent_window_finder_unit
    import ldwf_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration
    input  wire                    i_cfg_we,
    input  wire  [TMO_W-1:0]       i_cfg_wdata,
    // Input channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  signed [ALT_W-1:0] i_altitude_mm,
    input  wire  [TIME_BITS-1:0]   i_time_ms,
    input  wire                    i_first_sample,
    input  wire                    i_last_sample,
    // Output channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic                   o_range_found,
    output logic [TIME_BITS-1:0]   o_window_start_ms,
    output logic [TIME_BITS-1:0]   o_window_end_ms,
    output logic [DROP_W-1:0]      o_largest_drop_mm
);

    // Configuration register.
    t_tmo r_tmo;

    // Input register.
    logic  r_in_vld;
    t_alt  r_in_alt;
    t_time r_in_time;
    logic  r_in_first;
    logic  r_in_last;

    // Descent tracking state.
    t_alt  r_run_high;
    t_time r_run_high_time;
    t_alt  r_run_low;
    t_time r_run_low_time;
    t_drop r_best_drop;
    t_time r_best_high_time;
    t_time r_best_low_time;
    t_time r_track_start;

    // Closed-track snapshot waiting for the window calculation.
    logic r_fin_vld;
    t_fin r_fin;

    // Output register.
    logic  r_out_vld;
    logic  r_out_found;
    t_time r_out_start;
    t_time r_out_end;
    t_drop r_out_drop;

    // Handshake and advance control. A last sample may leave the input
    // register only when the snapshot register is free or draining.
    logic fin_adv;
    logic fin_free;
    logic s1_adv;

    assign fin_adv    = !r_out_vld || i_out_ready;
    assign fin_free   = !r_fin_vld || fin_adv;
    assign s1_adv     = r_in_vld && (!r_in_last || fin_free);
    assign o_in_ready = !r_in_vld || s1_adv;

    // ------------------------------------------------------------------
    // State update for the sample in the input register.
    // ------------------------------------------------------------------
    logic    alt_gt_high;
    logic    alt_le_low;
    logic    timeout_hit;
    t_time_x low_limit;
    t_drop   drop_old;
    t_drop   drop_ext;

    // Descent held after the sample, and the best closed descent before the
    // final close that a last sample performs.
    t_alt  n_run_high;
    t_time n_run_high_time;
    t_alt  n_run_low;
    t_time n_run_low_time;
    t_drop mid_drop;
    t_time mid_high_time;
    t_time mid_low_time;
    t_drop cand_drop;
    t_time n_track_start;
    t_drop n_best_drop;
    t_time n_best_high_time;
    t_time n_best_low_time;

    assign alt_gt_high = r_in_alt > r_run_high;
    assign alt_le_low  = r_in_alt <= r_run_low;
    // The pause exceeds the timeout exactly when the sample lies beyond the
    // low time plus the timeout; a timestamp that went backwards never does.
    assign low_limit   = {1'b0, r_run_low_time} + t_time_x'(r_tmo);
    assign timeout_hit = {1'b0, r_in_time} > low_limit;
    assign drop_old    = sat_drop(r_run_high, r_run_low);
    assign drop_ext    = sat_drop(r_run_high, r_in_alt);

    always_comb begin
        n_run_high      = r_run_high;
        n_run_high_time = r_run_high_time;
        n_run_low       = r_run_low;
        n_run_low_time  = r_run_low_time;
        mid_drop        = r_best_drop;
        mid_high_time   = r_best_high_time;
        mid_low_time    = r_best_low_time;
        n_track_start   = r_track_start;
        // Drop of the descent as it stands after this sample.
        cand_drop       = drop_old;

        priority if (r_in_first) begin
            n_run_high      = r_in_alt;
            n_run_high_time = r_in_time;
            n_run_low       = r_in_alt;
            n_run_low_time  = r_in_time;
            mid_drop        = '0;
            mid_high_time   = '0;
            mid_low_time    = '0;
            n_track_start   = r_in_time;
            cand_drop       = '0;
        end else if (alt_gt_high) begin
            n_run_high      = r_in_alt;
            n_run_high_time = r_in_time;
            n_run_low       = r_in_alt;
            n_run_low_time  = r_in_time;
            cand_drop       = '0;
        end else if (alt_le_low) begin
            n_run_low       = r_in_alt;
            n_run_low_time  = r_in_time;
            cand_drop       = drop_ext;
        end else if (timeout_hit) begin
            // Close the old descent, then start a new one at this sample.
            if (drop_old > r_best_drop) begin
                mid_drop      = drop_old;
                mid_high_time = r_run_high_time;
                mid_low_time  = r_run_low_time;
            end
            n_run_high      = r_in_alt;
            n_run_high_time = r_in_time;
            n_run_low       = r_in_alt;
            n_run_low_time  = r_in_time;
            cand_drop       = '0;
        end else begin
            cand_drop       = drop_old;
        end

        // The last sample closes the descent that remains open.
        n_best_drop      = mid_drop;
        n_best_high_time = mid_high_time;
        n_best_low_time  = mid_low_time;
        if (r_in_last && (cand_drop > mid_drop)) begin
            n_best_drop      = cand_drop;
            n_best_high_time = n_run_high_time;
            n_best_low_time  = n_run_low_time;
        end
    end

    // ------------------------------------------------------------------
    // Window calculation from the closed-track snapshot.
    // ------------------------------------------------------------------
    t_time   win_start_pad;
    t_time   win_start;
    t_time_x win_end_sum;
    t_time   win_end_pad;
    t_time   win_end;
    logic    win_found;

    always_comb begin
        win_start_pad = (r_fin.high_time > t_time'(r_tmo))
                        ? (r_fin.high_time - t_time'(r_tmo)) : '0;
        win_start     = (win_start_pad < r_fin.track_start)
                        ? r_fin.track_start : win_start_pad;
        win_end_sum   = {1'b0, r_fin.low_time} + t_time_x'(r_tmo);
        win_end_pad   = win_end_sum[TIME_BITS] ? '1 : win_end_sum[TIME_BITS-1:0];
        win_end       = (win_end_pad > r_fin.last_time) ? r_fin.last_time : win_end_pad;
        win_found     = (r_fin.drop != '0);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo            <= TMO_RESET;
            r_in_vld         <= 1'b0;
            r_fin_vld        <= 1'b0;
            r_out_vld        <= 1'b0;
            r_run_high       <= '0;
            r_run_high_time  <= '0;
            r_run_low        <= '0;
            r_run_low_time   <= '0;
            r_best_drop      <= '0;
            r_best_high_time <= '0;
            r_best_low_time  <= '0;
            r_track_start    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tmo <= i_cfg_wdata;
            end

            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (s1_adv) begin
                r_in_vld <= 1'b0;
            end

            if (s1_adv) begin
                r_run_high       <= n_run_high;
                r_run_high_time  <= n_run_high_time;
                r_run_low        <= n_run_low;
                r_run_low_time   <= n_run_low_time;
                r_best_drop      <= n_best_drop;
                r_best_high_time <= n_best_high_time;
                r_best_low_time  <= n_best_low_time;
                r_track_start    <= n_track_start;
            end

            if (s1_adv && r_in_last) begin
                r_fin_vld <= 1'b1;
            end else if (fin_adv) begin
                r_fin_vld <= 1'b0;
            end

            if (fin_adv) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_alt   <= i_altitude_mm;
            r_in_time  <= i_time_ms;
            r_in_first <= i_first_sample;
            r_in_last  <= i_last_sample;
        end
        if (s1_adv && r_in_last) begin
            r_fin.drop        <= n_best_drop;
            r_fin.high_time   <= n_best_high_time;
            r_fin.low_time    <= n_best_low_time;
            r_fin.track_start <= n_track_start;
            r_fin.last_time   <= r_in_time;
        end
        if (fin_adv && r_fin_vld) begin
            r_out_found <= win_found;
            r_out_start <= win_found ? win_start : '0;
            r_out_end   <= win_found ? win_end : '0;
            r_out_drop  <= r_fin.drop;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_range_found     = r_out_found;
    assign o_window_start_ms = r_out_start;
    assign o_window_end_ms   = r_out_end;
    assign o_largest_drop_mm = r_out_drop;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_found) |->
            ((o_window_start_ms == '0) && (o_window_end_ms == '0)
             && (o_largest_drop_mm == '0)))
        else $error("result without a descent carries nonzero fields");

    a_found_has_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_range_found == (o_largest_drop_mm != '0)))
        else $error("found flag disagrees with the drop");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_vld && !fin_adv) |=> r_fin_vld)
        else $error("closed-track snapshot lost while the output stalls");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_in_first) |=> (r_best_drop == '0))
        else $error("first sample did not clear the best descent");

endmodule
`default_nettype wire

/* sim/largest_descent_window_finder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Largest descent window finder unit testbench
// Streams altitude sample words into the unit and predicts every result word
// with an independent model of the descent tracking. Each result is compared
// field by field against the prediction. A directed section covers the corner
// cases and random phases follow with varied pause timeouts and idling.
// ----------------------------------------------------------------------------
module largest_descent_window_finder_unit_tb;
    import ldwf_pkg::*;

    localparam int    PIPE_CYCLES = 4;
    localparam int    DRAIN_LIMIT = 20000;
    localparam t_time TIME_TOP    = '1;

    typedef struct {
        logic  found;
        t_time start_ms;
        t_time stop_ms;
        t_drop drop_mm;
    } window_t;

    // DUT-facing signals; the inputs are all known from time zero.
    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_cfg_we       = 1'b0;
    t_tmo  i_cfg_wdata    = '0;
    logic  i_in_valid     = 1'b0;
    t_alt  i_altitude_mm  = '0;
    t_time i_time_ms      = '0;
    logic  i_first_sample = 1'b0;
    logic  i_last_sample  = 1'b0;
    logic  i_out_ready    = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    logic  o_range_found;
    t_time o_window_start_ms;
    t_time o_window_end_ms;
    t_drop o_largest_drop_mm;

    // Predictor state: the open descent, the best closed one and the track.
    t_tmo  pause_tmo_ms;
    t_alt  desc_high;
    t_alt  desc_low;
    t_time desc_high_ms;
    t_time desc_low_ms;
    t_drop best_drop_mm;
    t_time best_high_ms;
    t_time best_low_ms;
    t_time track_start_ms;

    window_t window_q[$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int words_sent    = 0;
    int tracks_opened = 0;
    int results_seen  = 0;
    int tmo_writes    = 0;
    int mismatches    = 0;

    largest_descent_window_finder_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_altitude_mm     (i_altitude_mm),
        .i_time_ms         (i_time_ms),
        .i_first_sample    (i_first_sample),
        .i_last_sample     (i_last_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_range_found     (o_range_found),
        .o_window_start_ms (o_window_start_ms),
        .o_window_end_ms   (o_window_end_ms),
        .o_largest_drop_mm (o_largest_drop_mm)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void restart_descent(input t_alt alt, input t_time t);
        desc_high    = alt;
        desc_high_ms = t;
        desc_low     = alt;
        desc_low_ms  = t;
    endfunction

    // Closes the open descent and keeps it if its drop beats the best one.
    function automatic void close_descent();
        longint diff;
        t_drop  drop;
        diff = longint'(desc_high) - longint'(desc_low);
        if (diff <= 0) begin
            drop = '0;
        end else if (diff > longint'(DROP_MAX)) begin
            drop = DROP_MAX;
        end else begin
            drop = t_drop'(diff);
        end
        if (drop > best_drop_mm) begin
            best_drop_mm = drop;
            best_high_ms = desc_high_ms;
            best_low_ms  = desc_low_ms;
        end
    endfunction

    // Advances the model by one sample word; returns 1 when a result is due.
    function automatic bit predict_window(input t_alt alt, input t_time t,
                                          input logic first, input logic last,
                                          output window_t w);
        t_time             pause;
        logic [TIME_BITS:0] wide_stop;
        w.found    = 1'b0;
        w.start_ms = '0;
        w.stop_ms  = '0;
        w.drop_mm  = '0;
        if (first) begin
            restart_descent(alt, t);
            best_drop_mm   = '0;
            best_high_ms   = '0;
            best_low_ms    = '0;
            track_start_ms = t;
        end else if (alt > desc_high) begin
            restart_descent(alt, t);
        end else if (alt <= desc_low) begin
            desc_low    = alt;
            desc_low_ms = t;
        end else begin
            // A timestamp behind the low counts as no pause at all.
            pause = (t >= desc_low_ms) ? t - desc_low_ms : '0;
            if (pause > pause_tmo_ms) begin
                close_descent();
                restart_descent(alt, t);
            end
        end
        if (!last) begin
            return 1'b0;
        end
        close_descent();
        if (best_drop_mm != '0) begin
            w.found    = 1'b1;
            w.drop_mm  = best_drop_mm;
            w.start_ms = (best_high_ms > pause_tmo_ms) ? best_high_ms - pause_tmo_ms : '0;
            if (w.start_ms < track_start_ms) begin
                w.start_ms = track_start_ms;
            end
            wide_stop = {1'b0, best_low_ms} + pause_tmo_ms;
            w.stop_ms = wide_stop[TIME_BITS] ? TIME_TOP : wide_stop[TIME_BITS-1:0];
            if (w.stop_ms > t) begin
                w.stop_ms = t;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        window_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (window_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual found=%0d",
                         $time, o_range_found);
                mismatches++;
            end else begin
                want = window_q.pop_front();
                check_field("range_found", want.found, o_range_found);
                check_field("window_start_ms", want.start_ms, o_window_start_ms);
                check_field("window_end_ms", want.stop_ms, o_window_end_ms);
                check_field("largest_drop_mm", want.drop_mm, o_largest_drop_mm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------
    // Offers one sample word, holding it until accepted, and logs the
    // prediction at the accepting edge.
    task automatic send_word(input t_alt alt, input t_time t,
                             input logic first, input logic last);
        window_t w;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_altitude_mm  <= alt;
        i_time_ms      <= t;
        i_first_sample <= first;
        i_last_sample  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_window(alt, t, first, last, w)) begin
            window_q.push_back(w);
        end
        words_sent++;
        if (first) begin
            tracks_opened++;
        end
    endtask

    // Drops valid, waits for all pending results, then lets the pipeline empty.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (window_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (window_q.size() != 0) begin
            $display("%0t: %0d result words missing, expected more, actual none",
                     $time, window_q.size());
            mismatches++;
            window_q.delete();
        end
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pause_timeout(input t_tmo value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        pause_tmo_ms = value;
        tmo_writes++;
    endtask

    // Moves a track along: mostly descending, with climbs, new highs and
    // pauses on both sides of the timeout, and now and then a step back.
    task automatic next_sample(inout t_alt alt, inout t_time t);
        int delta;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: delta = -int'($urandom_range(0, 60000));
            6, 7:             delta = $urandom_range(0, 40000);
            8:                delta = $urandom_range(0, 4000000);
            default:          delta = 0;
        endcase
        alt = t_alt'(int'(alt) + delta);
        case ($urandom_range(15))
            0:                      t = t;
            1, 2, 3, 4, 5, 6, 7, 8: t = t + $urandom_range(0, pause_tmo_ms);
            9:                      t = t + pause_tmo_ms;
            10:                     t = t + pause_tmo_ms + 1;
            11, 12, 13:             t = t + $urandom_range(pause_tmo_ms, 3 * pause_tmo_ms + 10);
            14:                     t = t - $urandom_range(0, 2 * pause_tmo_ms + 1);
            default:                t = t + $urandom_range(0, 100);
        endcase
    endtask

    task automatic send_random_track();
        t_alt  alt;
        t_time t;
        int    len;
        int    roll;
        roll = $urandom_range(99);
        len  = $urandom_range(1, 24);
        case ($urandom_range(9))
            0:       t = t_time'({$urandom, $urandom});
            1:       t = TIME_TOP - $urandom_range(0, 3 * pause_tmo_ms);
            default: t = $urandom_range(0, 2000000);
        endcase
        if ($urandom_range(9) == 0) begin
            alt = t_alt'($urandom);
        end else begin
            alt = t_alt'(int'($urandom_range(0, 21000000)) - 1000000);
        end
        if (roll < 85) begin
            send_word(alt, t, 1'b1, 1'b0);
            repeat (len) begin
                next_sample(alt, t);
                send_word(alt, t, 1'b0, 1'b0);
            end
            next_sample(alt, t);
            send_word(alt, t, 1'b0, 1'b1);
        end else begin
            // Broken tracks: flags anywhere, wild altitudes and times.
            repeat (len) begin
                next_sample(alt, t);
                if ($urandom_range(3) == 0) begin
                    alt = t_alt'($urandom);
                end
                if ($urandom_range(7) == 0) begin
                    t = t_time'({$urandom, $urandom});
                end
                send_word(alt, t, $urandom_range(3) == 0, $urandom_range(3) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Without a first sample the descent starts from the reset state.
    task automatic test_reset_state();
        send_word(t_alt'(-5), 48'd100, 1'b0, 1'b1);
    endtask

    // First and last on one word closes an empty track.
    task automatic test_single_sample_track();
        send_word(t_alt'(1234), 48'd5000, 1'b1, 1'b1);
    endtask

    task automatic test_drop_saturation();
        send_word(t_alt'(20000000), 48'd0, 1'b1, 1'b0);
        send_word(t_alt'(-1000000), 48'd1, 1'b0, 1'b1);
        send_word(26'sh1FFFFFF, 48'd0, 1'b1, 1'b0);
        send_word(26'sh2000000, 48'd10, 1'b0, 1'b0);
        send_word(26'sh2000000, 48'd20, 1'b0, 1'b1);
    endtask

    // A timestamp behind the low must never close the descent.
    task automatic test_time_backwards();
        send_word(t_alt'(100), 48'd1000, 1'b1, 1'b0);
        send_word(t_alt'(50), 48'd5000, 1'b0, 1'b0);
        send_word(t_alt'(70), 48'd3000, 1'b0, 1'b0);
        send_word(t_alt'(60), 48'd6000, 1'b0, 1'b1);
    endtask

    // A long pause closes the first descent; padding below zero clamps.
    task automatic test_pause_close();
        send_word(t_alt'(1000), 48'd0, 1'b1, 1'b0);
        send_word(t_alt'(500), 48'd100, 1'b0, 1'b0);
        send_word(t_alt'(800), 48'd20000, 1'b0, 1'b0);
        send_word(t_alt'(700), 48'd20100, 1'b0, 1'b0);
        send_word(t_alt'(750), 48'd20200, 1'b0, 1'b1);
    endtask

    // Tracking carries on past a last sample and reports again.
    task automatic test_samples_after_last();
        send_word(t_alt'(300), 48'd20300, 1'b0, 1'b0);
        send_word(t_alt'(200), 48'd20400, 1'b0, 1'b0);
        send_word(t_alt'(100), 48'd20500, 1'b0, 1'b1);
    endtask

    // End padding saturates at the top of the time range.
    task automatic test_time_ceiling();
        send_word(t_alt'(10), TIME_TOP - 4, 1'b1, 1'b0);
        send_word(t_alt'(0), TIME_TOP - 2, 1'b0, 1'b0);
        send_word(t_alt'(0), TIME_TOP, 1'b0, 1'b1);
    endtask

    task automatic test_random_phase(input int n_items, input int tx_idle,
                                     input int rx_stall, input t_tmo tmo);
        int first_word;
        set_pause_timeout(tmo);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        first_word   = words_sent;
        while (words_sent - first_word < n_items) begin
            send_random_track();
        end
        settle();
    endtask

    // The receiver holds off for a long stretch while short tracks keep
    // coming, so result words back up until the unit refuses samples.
    task automatic test_full_output_stall();
        t_time t;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 300;
        t = 48'd1000;
        repeat (20) begin
            send_word(t_alt'($urandom_range(5000, 9000)), t, 1'b1, 1'b0);
            send_word(t_alt'($urandom_range(0, 4999)), t + 10, 1'b0, 1'b0);
            send_word(t_alt'($urandom_range(0, 9000)), t + 20, 1'b0, 1'b1);
            t = t + 100;
        end
        settle();
    endtask

    initial begin
        pause_tmo_ms   = TMO_RESET;
        desc_high      = '0;
        desc_low       = '0;
        desc_high_ms   = '0;
        desc_low_ms    = '0;
        best_drop_mm   = '0;
        best_high_ms   = '0;
        best_low_ms    = '0;
        track_start_ms = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_single_sample_track();
        test_drop_saturation();
        test_time_backwards();
        test_pause_close();
        test_samples_after_last();
        test_time_ceiling();
        settle();

        test_random_phase(400, 0, 0, TMO_RESET);
        test_random_phase(400, 45, 0, t_tmo'(0));
        test_random_phase(400, 0, 45, t_tmo'(600000));
        test_full_output_stall();
        test_random_phase(350, 15, 15, '1);
        test_random_phase(150, 45, 45, t_tmo'($urandom_range(1, 5000)));
        settle();

        $display("Sent %0d sample words (%0d tracks opened), checked %0d result words.",
                 words_sent, tracks_opened, results_seen);
        $display("Pause timeout written %0d times, from zero to the full register range.",
                 tmo_writes);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
